FILE: design/bptc_pkg.sv
package bptc_pkg;

    // Field and datapath widths
    localparam int RawW     = 24;
    localparam int CalW     = 16;
    localparam int PresW    = 24;
    localparam int TempW    = 16;
    localparam int CfgIdxW  = 3;
    localparam int DtW      = 25;
    localparam int TW       = 24;
    localparam int WideW    = 48;
    localparam int AccW     = 72;
    localparam int SqW      = 40;
    localparam int PW       = 56;
    localparam int SensLoW  = 23;

    // Fixed points of the compensation
    localparam int TempRef  = 2000;
    localparam int TempLow  = -1500;
    localparam int TempMax  = 32767;
    localparam int TempMin  = -32768;
    localparam int PresMax  = 8388607;
    localparam int PresMin  = -8388608;
    localparam int TempDivSh = 23;
    localparam int SensDivSh = 21;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SENS          = 3'd0,
        REG_OFFSET        = 3'd1,
        REG_SENS_TEMPCO   = 3'd2,
        REG_OFFSET_TEMPCO = 3'd3,
        REG_TREF          = 3'd4,
        REG_TEMP_SENS     = 3'd5,
        REG_VARIANT       = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        VAR_FLOAT_A = 2'd0,
        VAR_FLOAT_B = 2'd1,
        VAR_INTEGER = 2'd2,
        VAR_WATER   = 2'd3
    } t_variant;

    typedef struct packed {
        logic [CalW-1:0] sens;
        logic [CalW-1:0] offset;
        logic [CalW-1:0] sens_tc;
        logic [CalW-1:0] offset_tc;
        logic [CalW-1:0] tref;
        logic [CalW-1:0] temp_sens;
        t_variant        variant;
    } t_cal;

    // Per-variant constants; every divisor is a power of two, kept as a shift
    typedef struct packed {
        logic [4:0] ko_sh;
        logic [4:0] dvo_sh;
        logic [4:0] ks_sh;
        logic [4:0] dvs_sh;
        logic       tm3;
        logic [5:0] tdv_sh;
        logic [5:0] a1;
        logic [2:0] b1_sh;
        logic [5:0] a2;
        logic [2:0] b2_sh;
        logic       extra;
        logic [4:0] e1;
        logic [1:0] f1_sh;
        logic [4:0] e2;
        logic [1:0] f2_sh;
        logic [3:0] dp_sh;
        logic       scale10;
    } t_coef;

    // Beat between the temperature and pressure halves
    typedef struct packed {
        logic [RawW-1:0]         d1;
        logic signed [TempW-1:0] temp;
        logic signed [WideW-1:0] off;
        logic signed [WideW-1:0] sens;
    } t_mid;

    function automatic t_coef coef_of(input t_variant v);
        t_coef c;
        c = '0;
        case (v)
            VAR_FLOAT_A: begin
                c = '{ko_sh: 5'd16, dvo_sh: 5'd7, ks_sh: 5'd15, dvs_sh: 5'd8,
                      tm3: 1'b0, tdv_sh: 6'd31, a1: 6'd5, b1_sh: 3'd1,
                      a2: 6'd5, b2_sh: 3'd2, extra: 1'b1, e1: 5'd7, f1_sh: 2'd0,
                      e2: 5'd11, f2_sh: 2'd1, dp_sh: 4'd15, scale10: 1'b0};
            end
            VAR_FLOAT_B: begin
                c = '{ko_sh: 5'd17, dvo_sh: 5'd6, ks_sh: 5'd16, dvs_sh: 5'd7,
                      tm3: 1'b0, tdv_sh: 6'd31, a1: 6'd61, b1_sh: 3'd4,
                      a2: 6'd2, b2_sh: 3'd0, extra: 1'b1, e1: 5'd15, f1_sh: 2'd0,
                      e2: 5'd8, f2_sh: 2'd0, dp_sh: 4'd15, scale10: 1'b0};
            end
            VAR_INTEGER: begin
                c = '{ko_sh: 5'd17, dvo_sh: 5'd6, ks_sh: 5'd16, dvs_sh: 5'd7,
                      tm3: 1'b1, tdv_sh: 6'd33, a1: 6'd61, b1_sh: 3'd4,
                      a2: 6'd29, b2_sh: 3'd4, extra: 1'b1, e1: 5'd17, f1_sh: 2'd0,
                      e2: 5'd9, f2_sh: 2'd0, dp_sh: 4'd15, scale10: 1'b0};
            end
            VAR_WATER: begin
                c = '{ko_sh: 5'd16, dvo_sh: 5'd7, ks_sh: 5'd15, dvs_sh: 5'd8,
                      tm3: 1'b1, tdv_sh: 6'd33, a1: 6'd3, b1_sh: 3'd1,
                      a2: 6'd5, b2_sh: 3'd3, extra: 1'b0, e1: 5'd0, f1_sh: 2'd0,
                      e2: 5'd0, f2_sh: 2'd0, dp_sh: 4'd13, scale10: 1'b1};
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    // Signed divide by 2^k, truncating toward zero
    function automatic logic signed [AccW-1:0] trunc_shr(
        input logic signed [AccW-1:0] x,
        input logic [6:0]             k
    );
        logic signed [AccW-1:0] shr;
        logic [AccW-1:0]        mask;
        logic                   corr;
        shr  = x >>> k;
        mask = (AccW'(1) << k) - AccW'(1);
        corr = x[AccW-1] && ((x & mask) != '0);
        return shr + AccW'(corr);
    endfunction

endpackage

FILE: design/bptc_in_if.sv
interface bptc_in_if;
    logic                        valid;
    logic                        ready;
    logic [bptc_pkg::RawW-1:0]   press_raw;
    logic [bptc_pkg::RawW-1:0]   temp_raw;

    modport source(output valid, output press_raw, output temp_raw, input ready);
    modport sink(input valid, input press_raw, input temp_raw, output ready);
endinterface

FILE: design/bptc_out_if.sv
interface bptc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bptc_pkg::PresW-1:0]  pressure_centimbar;
    logic signed [bptc_pkg::TempW-1:0]  temp_centideg;

    modport source(output valid, output pressure_centimbar, output temp_centideg, input ready);
    modport sink(input valid, input pressure_centimbar, input temp_centideg, output ready);
endinterface

FILE: design/bptc_cfg_regs.sv
module bptc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bptc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [bptc_pkg::CalW-1:0]    i_cfg_data,
    output bptc_pkg::t_cal               o_cal
);
    import bptc_pkg::*;

    t_cal r_cal;

    // Register writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SENS:          r_cal.sens      <= i_cfg_data;
                REG_OFFSET:        r_cal.offset    <= i_cfg_data;
                REG_SENS_TEMPCO:   r_cal.sens_tc   <= i_cfg_data;
                REG_OFFSET_TEMPCO: r_cal.offset_tc <= i_cfg_data;
                REG_TREF:          r_cal.tref      <= i_cfg_data;
                REG_TEMP_SENS:     r_cal.temp_sens <= i_cfg_data;
                REG_VARIANT:       r_cal.variant   <= t_variant'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign o_cal = r_cal;
endmodule

FILE: design/bptc_temp_pipe.sv
module bptc_temp_pipe (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bptc_pkg::t_cal            i_cal,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [bptc_pkg::RawW-1:0] i_d1,
    input  logic [bptc_pkg::RawW-1:0] i_d2,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output bptc_pkg::t_mid            o_out
);
    import bptc_pkg::*;

    localparam int NStg = 6;

    t_coef            coef;
    logic [NStg:1]    r_v;
    logic [NStg+1:1]  rdy;

    // stage 1: dT
    logic signed [DtW-1:0]    n1_dt, r1_dt;
    logic [RawW-1:0]          r1_d1;
    // stage 2: products
    logic signed [41:0]       r2_tc6, r2_c4dt, r2_c3dt;
    logic signed [49:0]       r2_dtsq;
    logic [RawW-1:0]          r2_d1;
    // stage 3: first order terms
    logic signed [AccW-1:0]   n3_tq, n3_oq, n3_sq;
    logic signed [TW-1:0]     n3_temp, r3_temp;
    logic signed [WideW-1:0]  n3_off, n3_sens, r3_off, r3_sens;
    logic [51:0]              n3_tsq;
    logic [TW-1:0]            n3_t2, r3_t2;
    logic [RawW-1:0]          r3_d1;
    // stage 4: squares of temperature deviation
    logic signed [TW-1:0]     n4_q, n4_bq;
    logic signed [WideW-1:0]  n4_a, n4_b;
    logic [SqW-1:0]           r4_a, r4_b;
    logic                     r4_lo, r4_ex;
    logic signed [TW-1:0]     r4_temp;
    logic [TW-1:0]            r4_t2;
    logic signed [WideW-1:0]  r4_off, r4_sens;
    logic [RawW-1:0]          r4_d1;
    // stage 5: second order corrections
    logic [WideW-1:0]         n5_off2, n5_sens2, r5_off2, r5_sens2;
    logic                     r5_lo;
    logic signed [TW-1:0]     r5_temp;
    logic [TW-1:0]            r5_t2;
    logic signed [WideW-1:0]  r5_off, r5_sens;
    logic [RawW-1:0]          r5_d1;
    // stage 6: apply corrections, saturate temperature
    logic signed [TW-1:0]     n6_temp;
    t_mid                     n6_out, r6_out;

    assign coef = coef_of(i_cal.variant);

    // Per-stage ready: a stage loads when empty or when it moves on
    always_comb begin
        rdy[NStg+1] = i_out_ready;
        for (int k = NStg; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) r_v[1] <= i_in_valid;
            for (int k = 2; k <= NStg; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1
    assign n1_dt = signed'({1'b0, i_d2}) - signed'({1'b0, i_cal.tref, 8'h00});
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_dt <= n1_dt;
            r1_d1 <= i_d1;
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_tc6  <= r1_dt * signed'({1'b0, i_cal.temp_sens});
            r2_c4dt <= r1_dt * signed'({1'b0, i_cal.offset_tc});
            r2_c3dt <= r1_dt * signed'({1'b0, i_cal.sens_tc});
            r2_dtsq <= r1_dt * r1_dt;
            r2_d1   <= r1_d1;
        end
    end

    // stage 3
    always_comb begin
        n3_tq   = trunc_shr(AccW'(r2_tc6), 7'(TempDivSh));
        n3_oq   = trunc_shr(AccW'(r2_c4dt), 7'(coef.dvo_sh));
        n3_sq   = trunc_shr(AccW'(r2_c3dt), 7'(coef.dvs_sh));
        n3_temp = TW'(TempRef) + n3_tq[TW-1:0];
        n3_off  = (WideW'(i_cal.offset) << coef.ko_sh) + n3_oq[WideW-1:0];
        n3_sens = (WideW'(i_cal.sens) << coef.ks_sh) + n3_sq[WideW-1:0];
        n3_tsq  = 52'(r2_dtsq[47:0]) + (coef.tm3 ? {3'b000, r2_dtsq[47:0], 1'b0} : 52'd0);
        n3_t2   = TW'(n3_tsq >> coef.tdv_sh);
    end
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_temp <= n3_temp;
            r3_off  <= n3_off;
            r3_sens <= n3_sens;
            r3_t2   <= n3_t2;
            r3_d1   <= r2_d1;
        end
    end

    // stage 4
    always_comb begin
        n4_q  = r3_temp - TW'(TempRef);
        n4_bq = r3_temp - TW'(TempLow);
        n4_a  = n4_q * n4_q;
        n4_b  = n4_bq * n4_bq;
    end
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_a    <= n4_a[SqW-1:0];
            r4_b    <= n4_b[SqW-1:0];
            r4_lo   <= r3_temp < TW'(TempRef);
            r4_ex   <= coef.extra && (r3_temp < TW'(TempLow));
            r4_temp <= r3_temp;
            r4_t2   <= r3_t2;
            r4_off  <= r3_off;
            r4_sens <= r3_sens;
            r4_d1   <= r3_d1;
        end
    end

    // stage 5
    always_comb begin
        n5_off2  = ((WideW'(coef.a1) * WideW'(r4_a)) >> coef.b1_sh)
                 + (r4_ex ? ((WideW'(coef.e1) * WideW'(r4_b)) >> coef.f1_sh) : '0);
        n5_sens2 = ((WideW'(coef.a2) * WideW'(r4_a)) >> coef.b2_sh)
                 + (r4_ex ? ((WideW'(coef.e2) * WideW'(r4_b)) >> coef.f2_sh) : '0);
    end
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_off2  <= n5_off2;
            r5_sens2 <= n5_sens2;
            r5_lo    <= r4_lo;
            r5_temp  <= r4_temp;
            r5_t2    <= r4_t2;
            r5_off   <= r4_off;
            r5_sens  <= r4_sens;
            r5_d1    <= r4_d1;
        end
    end

    // stage 6
    always_comb begin
        n6_temp     = r5_temp - (r5_lo ? signed'(r5_t2) : '0);
        n6_out.d1   = r5_d1;
        n6_out.off  = r5_off - (r5_lo ? signed'(r5_off2) : '0);
        n6_out.sens = r5_sens - (r5_lo ? signed'(r5_sens2) : '0);
        if (n6_temp > TW'(TempMax)) begin
            n6_out.temp = TempW'(TempMax);
        end else if (n6_temp < signed'(TW'(TempMin))) begin
            n6_out.temp = TempW'(TempMin);
        end else begin
            n6_out.temp = n6_temp[TempW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (rdy[6]) r6_out <= n6_out;
    end

    assign o_in_ready  = rdy[1];
    assign o_out_valid = r_v[NStg];
    assign o_out       = r6_out;
endmodule

FILE: design/bptc_press_pipe.sv
module bptc_press_pipe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bptc_pkg::t_cal                    i_cal,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bptc_pkg::t_mid                    i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [bptc_pkg::PresW-1:0] o_pres,
    output logic signed [bptc_pkg::TempW-1:0] o_temp
);
    import bptc_pkg::*;

    localparam int NStg = 5;

    t_coef            coef;
    logic [NStg:1]    r_v;
    logic [NStg+1:1]  rdy;

    // stage 1: split product D1 * SENS
    logic [46:0]              r1_lo;
    logic signed [49:0]       r1_hi;
    logic signed [WideW-1:0]  r1_off;
    logic signed [TempW-1:0]  r1_temp;
    // stage 2: recombine
    logic signed [AccW-1:0]   r2_sum;
    logic signed [WideW-1:0]  r2_off;
    logic signed [TempW-1:0]  r2_temp;
    // stage 3: scale and remove offset
    logic signed [AccW-1:0]   n3_x;
    logic signed [PW-1:0]     r3_x;
    logic signed [TempW-1:0]  r3_temp;
    // stage 4: final divide
    logic signed [AccW-1:0]   n4_y;
    logic signed [PW-1:0]     r4_y;
    logic signed [TempW-1:0]  r4_temp;
    // stage 5: scale, saturate
    logic signed [PW-1:0]     n5_p;
    logic signed [PresW-1:0]  n5_sat, r5_pres;
    logic signed [TempW-1:0]  r5_temp;

    assign coef = coef_of(i_cal.variant);

    always_comb begin
        rdy[NStg+1] = i_out_ready;
        for (int k = NStg; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) r_v[1] <= i_in_valid;
            for (int k = 2; k <= NStg; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_lo   <= i_in.d1 * i_in.sens[SensLoW-1:0];
            r1_hi   <= signed'({1'b0, i_in.d1}) * signed'(i_in.sens[WideW-1:SensLoW]);
            r1_off  <= i_in.off;
            r1_temp <= i_in.temp;
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_sum  <= (AccW'(r1_hi) <<< SensLoW) + AccW'(r1_lo);
            r2_off  <= r1_off;
            r2_temp <= r1_temp;
        end
    end

    // stage 3
    assign n3_x = trunc_shr(r2_sum, 7'(SensDivSh)) - AccW'(r2_off);
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_x    <= n3_x[PW-1:0];
            r3_temp <= r2_temp;
        end
    end

    // stage 4
    assign n4_y = trunc_shr(AccW'(r3_x), 7'(coef.dp_sh));
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_y    <= n4_y[PW-1:0];
            r4_temp <= r3_temp;
        end
    end

    // stage 5: times ten for the water variant
    always_comb begin
        n5_p = coef.scale10 ? (r4_y <<< 3) + (r4_y <<< 1) : r4_y;
        if (n5_p > PW'(PresMax)) begin
            n5_sat = PresW'(PresMax);
        end else if (n5_p < signed'(PW'(PresMin))) begin
            n5_sat = PresW'(PresMin);
        end else begin
            n5_sat = n5_p[PresW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_pres <= n5_sat;
            r5_temp <= r4_temp;
        end
    end

    assign o_in_ready  = rdy[1];
    assign o_out_valid = r_v[NStg];
    assign o_pres      = r5_pres;
    assign o_temp      = r5_temp;
endmodule

FILE: design/baro_pressure_temp_compensation.sv
// Barometric pressure and temperature compensation.
// Input channel i_in carries one beat per sample: raw 24-bit pressure and
// temperature conversions. Output channel o_out carries one beat per sample:
// pressure in 0.01 mbar (signed 24, saturated) and temperature in 0.01 C
// (signed 16, saturated). Both are valid/ready; a beat moves when both high.
// Calibration words and the sensor variant are written through i_cfg_we,
// i_cfg_idx, i_cfg_data; index 7 is ignored. The user must write them only
// while no sample is in flight; the block does not enforce this. Pipeline:
// 6 stages for the temperature and correction terms, then 5 for the split
// D1*SENS product, offset removal, final divide and saturation. Throughput:
// one sample per cycle while the receiver takes beats; each stage holds one
// beat with its own valid bit and loads whenever it is empty or its contents
// move on. When the receiver stalls, beats pile up into empty stages;
// i_in.ready drops only once every stage holds a beat. Nothing is dropped or
// repeated. Reset (synchronous, active low) empties the pipeline and clears
// all calibration registers and the variant to zero.
module baro_pressure_temp_compensation (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bptc_in_if.sink                      i_in,
    bptc_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [bptc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [bptc_pkg::CalW-1:0]    i_cfg_data
);
    import bptc_pkg::*;

    t_cal cal;
    t_mid mid;
    logic mid_valid;
    logic mid_ready;

    bptc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cal      (cal)
    );

    bptc_temp_pipe u_temp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cal       (cal),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_d1        (i_in.press_raw),
        .i_d2        (i_in.temp_raw),
        .o_out_valid (mid_valid),
        .i_out_ready (mid_ready),
        .o_out       (mid)
    );

    bptc_press_pipe u_press (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cal       (cal),
        .i_in_valid  (mid_valid),
        .o_in_ready  (mid_ready),
        .i_in        (mid),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_pres      (o_out.pressure_centimbar),
        .o_temp      (o_out.temp_centideg)
    );

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // With the output stage empty, every stage can load, so input is ready
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output stage");

    // Beat crossing into the pressure half always finds room when output is empty
    a_mid_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> mid_ready)
        else $error("pressure pipe stalled with empty output stage");
endmodule

FILE: tb/baro_pressure_temp_compensation_test.sv
module baro_pressure_temp_compensation_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bptc_pkg::*;

    // Compensation coefficients, one set per sensor variant
    typedef struct {
        longint ko, dvo, ks, dvs, tm, tdv, a1, b1, a2, b2;
        bit     extra;
        longint e1, f1, e2, f2, pdv, pscale;
    } t_var_coef;

    typedef struct {
        logic [PresW-1:0] pres;
        logic [TempW-1:0] temp;
    } t_sample_out;

    // Directed stimulus row; has_exp marks rows with a hand-written result
    typedef struct {
        logic [RawW-1:0]  d1;
        logic [RawW-1:0]  d2;
        bit               has_exp;
        logic [PresW-1:0] pres;
        logic [TempW-1:0] temp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CalW-1:0] i_cfg_data = '0;

    bptc_in_if  in_ch();
    bptc_out_if out_ch();

    baro_pressure_temp_compensation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the calibration registers
    longint cal_c1, cal_c2, cal_c3, cal_c4, cal_c5, cal_c6;
    t_variant cal_var;

    t_sample_out expected_q[$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    bit idle_sink = 1'b1;

    function automatic t_var_coef coefs_for(t_variant v);
        t_var_coef k;
        case (v)
            VAR_FLOAT_A: k = '{65536, 128, 32768, 256, 1, 64'h80000000, 5, 2, 5, 4,
                               1'b1, 7, 1, 11, 2, 32768, 1};
            VAR_FLOAT_B: k = '{131072, 64, 65536, 128, 1, 64'h80000000, 61, 16, 2, 1,
                               1'b1, 15, 1, 8, 1, 32768, 1};
            VAR_INTEGER: k = '{131072, 64, 65536, 128, 3, 64'd8589934592, 61, 16, 29, 16,
                               1'b1, 17, 1, 9, 1, 32768, 1};
            default:     k = '{65536, 128, 32768, 256, 3, 64'd8589934592, 3, 2, 5, 8,
                               1'b0, 0, 1, 0, 1, 8192, 10};
        endcase
        return k;
    endfunction

    // Compensated pressure and temperature for one raw pair
    function automatic t_sample_out compensate(logic [RawW-1:0] raw_p, logic [RawW-1:0] raw_t);
        t_var_coef k;
        longint dt, t, off, sens, t2, a, b, off2, sens2, p;
        t_sample_out r;
        k = coefs_for(cal_var);
        dt = longint'(raw_t) - cal_c5 * 256;
        t = 2000 + (dt * cal_c6) / 8388608;
        off = cal_c2 * k.ko + (cal_c4 * dt) / k.dvo;
        sens = cal_c1 * k.ks + (cal_c3 * dt) / k.dvs;
        if (t < 2000) begin
            t2 = (k.tm * (dt * dt)) / k.tdv;
            a = (t - 2000) * (t - 2000);
            off2 = (k.a1 * a) / k.b1;
            sens2 = (k.a2 * a) / k.b2;
            // extra cold correction below -15 C
            if (k.extra && t < -1500) begin
                b = (t + 1500) * (t + 1500);
                off2 += (k.e1 * b) / k.f1;
                sens2 += (k.e2 * b) / k.f2;
            end
            t -= t2;
            off -= off2;
            sens -= sens2;
        end
        p = ((longint'(raw_p) * sens) / 2097152 - off) / k.pdv * k.pscale;
        if (p > PresMax) p = longint'(PresMax);
        if (p < PresMin) p = longint'(PresMin);
        if (t > TempMax) t = longint'(TempMax);
        if (t < TempMin) t = longint'(TempMin);
        r.pres = p[PresW-1:0];
        r.temp = t[TempW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s at output beat %0d: got %0d want %0d", what, beats_out, got, want);
        errors++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CalW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_SENS:          cal_c1 = longint'(val);
            REG_OFFSET:        cal_c2 = longint'(val);
            REG_SENS_TEMPCO:   cal_c3 = longint'(val);
            REG_OFFSET_TEMPCO: cal_c4 = longint'(val);
            REG_TREF:          cal_c5 = longint'(val);
            REG_TEMP_SENS:     cal_c6 = longint'(val);
            REG_VARIANT:       cal_var = t_variant'(val[1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Write the unused index; nothing should change
    task automatic write_unused(logic [CalW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= '1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cal(logic [CalW-1:0] c1, logic [CalW-1:0] c2, logic [CalW-1:0] c3,
                            logic [CalW-1:0] c4, logic [CalW-1:0] c5, logic [CalW-1:0] c6,
                            t_variant v);
        write_reg(REG_SENS, c1);
        write_reg(REG_OFFSET, c2);
        write_reg(REG_SENS_TEMPCO, c3);
        write_reg(REG_OFFSET_TEMPCO, c4);
        write_reg(REG_TREF, c5);
        write_reg(REG_TEMP_SENS, c6);
        write_reg(REG_VARIANT, 16'(v));
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one beat; expectation queued when it is accepted.
    // Valid stays high into the next beat unless a gap follows.
    task automatic send_sample(logic [RawW-1:0] p, logic [RawW-1:0] t, bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g != 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.press_raw <= p;
        in_ch.temp_raw <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_q.push_back(compensate(p, t));
        beats_in++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Random pair biased toward the cold, mid and hot regions around the tref word
    task automatic random_sample(bit idle);
        logic [RawW-1:0] p, t;
        int sel;
        p = RawW'($urandom_range(0, 16777215));
        sel = $urandom_range(0, 3);
        if (sel == 0) t = RawW'($urandom_range(0, 16777215));
        else if (sel == 1) t = 24'((cal_c5 * 256 + $urandom_range(0, 4000000)) & 24'hFFFFFF);
        else t = 24'((cal_c5 * 256 - $urandom_range(0, 4000000)) & 24'hFFFFFF);
        send_sample(p, t, idle);
    endtask

    // Output side: random stall, compare against oldest expectation
    initial begin
        t_sample_out w;
        int g;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            g = idle_sink ? gap_len() : 0;
            if (g != 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                beats_out++;
                if (expected_q.size() == 0) begin
                    $display("MISMATCH unexpected output beat %0d", beats_out);
                    errors++;
                end else begin
                    w = expected_q.pop_front();
                    if (out_ch.pressure_centimbar !== w.pres)
                        report_mismatch("pressure", longint'($signed(out_ch.pressure_centimbar)),
                                        longint'($signed(w.pres)));
                    if (out_ch.temp_centideg !== w.temp)
                        report_mismatch("temperature", longint'($signed(out_ch.temp_centideg)),
                                        longint'($signed(w.temp)));
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Timeout with %0d beats pending", expected_q.size());
        $display("Verification failed");
        $finish;
    end

    // Directed rows, walked once per calibration set
    t_row rows[$];

    initial begin
        t_sample_out r;
        in_ch.valid = 1'b0;
        in_ch.press_raw = '0;
        in_ch.temp_raw = '0;
        cal_c1 = 0; cal_c2 = 0; cal_c3 = 0; cal_c4 = 0; cal_c5 = 0; cal_c6 = 0;
        cal_var = VAR_FLOAT_A;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset all calibration is zero: temp 2000, pressure 0
        rows.push_back('{24'd0, 24'd0, 1'b1, 24'd0, 16'd2000});
        rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'd0, 16'd2000});
        rows.push_back('{24'h800000, 24'h000001, 1'b1, 24'd0, 16'd2000});
        foreach (rows[i]) begin
            send_sample(rows[i].d1, rows[i].d2, 1'b0);
            r = expected_q[$];
            if (r.pres !== rows[i].pres || r.temp !== rows[i].temp)
                report_mismatch("directed row", longint'(r.temp), longint'(rows[i].temp));
        end
        drain();

        // Typical calibration, each variant; hot, nominal, cold, very cold, extremes
        rows.delete();
        rows.push_back('{24'd9085466, 24'd8569150, 1'b0, '0, '0});
        rows.push_back('{24'd9085466, 24'd8077636, 1'b0, '0, '0});
        rows.push_back('{24'd6000000, 24'd6000000, 1'b0, '0, '0});
        rows.push_back('{24'd4000000, 24'd2000000, 1'b0, '0, '0});
        rows.push_back('{24'hFFFFFF, 24'd0, 1'b0, '0, '0});
        rows.push_back('{24'd0, 24'hFFFFFF, 1'b0, '0, '0});
        rows.push_back('{24'hAAAAAA, 24'h555555, 1'b0, '0, '0});
        rows.push_back('{24'h555555, 24'hAAAAAA, 1'b0, '0, '0});
        for (int v = 0; v < 4; v++) begin
            load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312,
                     t_variant'(v));
            write_unused(16'hFFFF);
            foreach (rows[i]) send_sample(rows[i].d1, rows[i].d2, 1'b0);
            drain();
        end

        // Extreme calibrations: all ones, then mixed
        load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, VAR_WATER);
        foreach (rows[i]) send_sample(rows[i].d1, rows[i].d2, 1'b1);
        drain();
        load_cal(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, VAR_INTEGER);
        foreach (rows[i]) send_sample(rows[i].d1, rows[i].d2, 1'b1);
        drain();

        // Random phases with random calibration; one phase without idling
        for (int ph = 0; ph < 8; ph++) begin
            load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), t_variant'($urandom_range(0, 3)));
            idle_sink = (ph != 3);
            repeat (50) random_sample(ph != 3);
            drain();
        end
        idle_sink = 1'b1;

        $display("Sent %0d samples, checked %0d results over 4 variants and %0d calibrations",
                 beats_in, beats_out, 15);
        $display("Directed extremes, cold corrections and saturation plus random raw pairs");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
design/bptc_pkg.sv
design/bptc_in_if.sv
design/bptc_out_if.sv
design/bptc_cfg_regs.sv
design/bptc_temp_pipe.sv
design/bptc_press_pipe.sv
design/baro_pressure_temp_compensation.sv
tb/baro_pressure_temp_compensation_test.sv
